@@ rtl/core/srsi_pkg.sv @@
// ----------------------------------------------------------------------------
// srsi_pkg
// Shared constants and controller/datapath interface types for the
// stochastic RSI filter.
// ----------------------------------------------------------------------------
package srsi_pkg;

   localparam int ValW      = 23;               // fixed point sample width
   localparam int FracBits  = 16;
   localparam int KpMax     = 64;               // ring depth
   localparam int SlotW     = 6;                // ring index width
   localparam int KpW       = 7;                // k_period / rsi run width
   localparam int SmMax     = 16;               // smooth and d window depth
   localparam int SmIdxW    = 4;
   localparam int SmW       = 5;                // length / run width
   localparam int ProdW     = 2 * ValW;
   localparam int AccW      = 27;
   localparam int CntW      = 6;
   localparam int DivSteps  = ValW;
   localparam int CsrIdxW   = 2;

   localparam logic [ValW-1:0] RawScale = ValW'(100 << FracBits);

   localparam logic [CsrIdxW-1:0] CSR_K_PERIOD = 2'd0;
   localparam logic [CsrIdxW-1:0] CSR_SMOOTH   = 2'd1;
   localparam logic [CsrIdxW-1:0] CSR_D_LEN    = 2'd2;

   // divider operand select, also selects the window summed
   localparam logic [1:0] SEL_RAW = 2'd0;
   localparam logic [1:0] SEL_K   = 2'd1;
   localparam logic [1:0] SEL_D   = 2'd2;

   typedef struct packed {
      logic            load;      // take the input item
      logic            scan_rd;   // read ring entry idx back from newest
      logic            mul;
      logic            div_ld;
      logic            div_step;
      logic [1:0]      sel;
      logic            shift_raw;
      logic            sum_add;
      logic            shift_k;
      logic            load_out;
      logic [CntW-1:0] idx;
   } srsi_cmd_type;

   typedef struct packed {
      logic           raw_ok;
      logic           k_ok;
      logic           d_ok;
      logic           flat;
      logic [KpW-1:0] kp;
      logic [SmW-1:0] sl;
      logic [SmW-1:0] dl;
   } srsi_sts_type;

endpackage

@@ rtl/core/srsi_dp.sv @@
// ----------------------------------------------------------------------------
// srsi_dp
// Datapath: sample ring, min/max scan, scaling multiply, shared restoring
// divider, raw and %K windows with running accumulator, output registers.
// ----------------------------------------------------------------------------
module srsi_dp import srsi_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_we,
   input  logic [CsrIdxW-1:0]  csr_index,
   input  logic [KpW-1:0]      csr_wdata,
   input  logic [ValW-1:0]     req_rsi_value,
   input  logic                req_rsi_valid,
   input  srsi_cmd_type        cmd,
   output srsi_sts_type        sts,
   output logic [ValW-1:0]     rsp_k_value,
   output logic                rsp_k_valid,
   output logic [ValW-1:0]     rsp_d_value,
   output logic                rsp_d_valid
);

   logic [KpW-1:0]   k_period_ff;
   logic [SmW-1:0]   smooth_len_ff, d_len_ff;
   logic [KpW-1:0]   kp;
   logic [SmW-1:0]   sl, dl;

   logic [ValW-1:0]  ring [KpMax];
   logic [SlotW-1:0] wslot_ff, slot_cur_ff;
   logic [ValW-1:0]  v_ff, rdata_ff, mn_ff, mx_ff;
   logic             scan_vld_ff;
   logic [KpW-1:0]   rsi_run_ff;
   logic [SmW-1:0]   raw_run_ff, k_run_ff;

   logic [ProdW-1:0] prod_ff;
   logic [ValW-1:0]  rem_ff, nlo_ff, den_ff, rem_in;
   logic [ValW:0]    div_t;
   logic             div_ge;

   logic [ValW-1:0]  raw_win [SmMax];
   logic [ValW-1:0]  k_win [SmMax];
   logic [AccW-1:0]  acc_ff;
   logic [ValW-1:0]  raw_val, k_val, kv_ff, sum_src;

   // length registers: zero acts as one, too large acts as the maximum
   always_comb begin
      kp = k_period_ff;
      if (k_period_ff == '0) kp = KpW'(1);
      else if (k_period_ff > KpW'(KpMax)) kp = KpW'(KpMax);
      sl = smooth_len_ff;
      if (smooth_len_ff == '0) sl = SmW'(1);
      else if (smooth_len_ff > SmW'(SmMax)) sl = SmW'(SmMax);
      dl = d_len_ff;
      if (d_len_ff == '0) dl = SmW'(1);
      else if (d_len_ff > SmW'(SmMax)) dl = SmW'(SmMax);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         k_period_ff   <= KpW'(14);
         smooth_len_ff <= SmW'(3);
         d_len_ff      <= SmW'(3);
      end else if (csr_we) begin
         case (csr_index)
            CSR_K_PERIOD: k_period_ff   <= csr_wdata;
            CSR_SMOOTH:   smooth_len_ff <= csr_wdata[SmW-1:0];
            CSR_D_LEN:    d_len_ff      <= csr_wdata[SmW-1:0];
            default: ;
         endcase
      end
   end

   // sample ring
   always_ff @(posedge clock) begin
      if (cmd.load) ring[wslot_ff] <= req_rsi_value;
      if (cmd.scan_rd) rdata_ff <= ring[slot_cur_ff - cmd.idx];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wslot_ff    <= '0;
         rsi_run_ff  <= '0;
         raw_run_ff  <= '0;
         k_run_ff    <= '0;
         scan_vld_ff <= 1'b0;
      end else begin
         scan_vld_ff <= cmd.scan_rd;
         if (cmd.load) begin
            wslot_ff <= wslot_ff + SlotW'(1);
            if (!req_rsi_valid) rsi_run_ff <= '0;
            else if (rsi_run_ff < KpW'(KpMax)) rsi_run_ff <= rsi_run_ff + KpW'(1);
         end
         if (cmd.shift_raw) begin
            if (!sts.raw_ok) raw_run_ff <= '0;
            else if (raw_run_ff < SmW'(SmMax)) raw_run_ff <= raw_run_ff + SmW'(1);
         end
         if (cmd.shift_k) begin
            if (!sts.k_ok) k_run_ff <= '0;
            else if (k_run_ff < SmW'(SmMax)) k_run_ff <= k_run_ff + SmW'(1);
         end
      end
   end

   // min/max scan and scaling
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         slot_cur_ff <= wslot_ff;
         v_ff        <= req_rsi_value;
         mn_ff       <= '1;
         mx_ff       <= '0;
      end else if (scan_vld_ff) begin
         if (rdata_ff < mn_ff) mn_ff <= rdata_ff;
         if (rdata_ff > mx_ff) mx_ff <= rdata_ff;
      end
      if (cmd.mul) prod_ff <= ProdW'(v_ff - mn_ff) * ProdW'(RawScale);
   end

   // restoring divider; quotient always fits ValW bits, so only the low
   // half of the dividend needs stepping
   assign div_t  = {rem_ff, nlo_ff[ValW-1]};
   assign div_ge = div_t >= {1'b0, den_ff};
   assign rem_in = div_ge ? ValW'(div_t - {1'b0, den_ff}) : div_t[ValW-1:0];

   always_ff @(posedge clock) begin
      if (cmd.div_ld) begin
         case (cmd.sel)
            SEL_RAW: begin
               rem_ff <= prod_ff[ProdW-1:ValW];
               nlo_ff <= prod_ff[ValW-1:0];
               den_ff <= mx_ff - mn_ff;
            end
            SEL_K: begin
               rem_ff <= ValW'(acc_ff >> ValW);
               nlo_ff <= acc_ff[ValW-1:0];
               den_ff <= ValW'(sl);
            end
            default: begin
               rem_ff <= ValW'(acc_ff >> ValW);
               nlo_ff <= acc_ff[ValW-1:0];
               den_ff <= ValW'(dl);
            end
         endcase
      end else if (cmd.div_step) begin
         rem_ff <= rem_in;
         nlo_ff <= {nlo_ff[ValW-2:0], div_ge};
      end
   end

   // averaging windows, newest at entry 0
   assign raw_val = (sts.raw_ok && !sts.flat) ? nlo_ff : '0;
   assign k_val   = sts.k_ok ? nlo_ff : '0;
   assign sum_src = (cmd.sel == SEL_K) ? raw_win[cmd.idx[SmIdxW-1:0]]
                                       : k_win[cmd.idx[SmIdxW-1:0]];

   always_ff @(posedge clock) begin
      if (cmd.shift_raw) begin
         for (int i = SmMax - 1; i > 0; i--) raw_win[i] <= raw_win[i-1];
         raw_win[0] <= raw_val;
      end
      if (cmd.shift_k) begin
         for (int i = SmMax - 1; i > 0; i--) k_win[i] <= k_win[i-1];
         k_win[0] <= k_val;
         kv_ff    <= k_val;
      end
      if (cmd.shift_raw || cmd.shift_k) acc_ff <= '0;
      else if (cmd.sum_add) acc_ff <= acc_ff + AccW'(sum_src);
   end

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         rsp_k_value <= kv_ff;
         rsp_k_valid <= (raw_run_ff >= sl);
         rsp_d_value <= sts.d_ok ? nlo_ff : '0;
         rsp_d_valid <= sts.d_ok;
      end
   end

   assign sts.raw_ok = rsi_run_ff >= kp;
   assign sts.k_ok   = raw_run_ff >= sl;
   assign sts.d_ok   = k_run_ff >= dl;
   assign sts.flat   = mx_ff == mn_ff;
   assign sts.kp     = kp;
   assign sts.sl     = sl;
   assign sts.dl     = dl;

endmodule

@@ rtl/core/srsi_ctrl.sv @@
// ----------------------------------------------------------------------------
// srsi_ctrl
// Sequencer: steps one item through scan, scale, divide, and both averages,
// and owns the input and result handshakes.
// ----------------------------------------------------------------------------
module srsi_ctrl import srsi_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   input  srsi_sts_type  sts,
   output srsi_cmd_type  cmd
);

   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_CHK  = 4'd1;
   localparam logic [3:0] S_SCAN = 4'd2;
   localparam logic [3:0] S_SCWT = 4'd3;
   localparam logic [3:0] S_MUL  = 4'd4;
   localparam logic [3:0] S_DLD  = 4'd5;
   localparam logic [3:0] S_DIV  = 4'd6;
   localparam logic [3:0] S_SHR  = 4'd7;
   localparam logic [3:0] S_CHK2 = 4'd8;
   localparam logic [3:0] S_SUM  = 4'd9;
   localparam logic [3:0] S_SHK  = 4'd10;
   localparam logic [3:0] S_CHK3 = 4'd11;
   localparam logic [3:0] S_OUT  = 4'd12;
   localparam logic [3:0] S_SETL = 4'd13;

   logic [3:0]      state_ff, state_in;
   logic [CntW-1:0] cnt_ff, cnt_in;
   logic [1:0]      sel_ff, sel_in;
   logic            rsp_valid_ff, rsp_valid_in;
   logic [SmW-1:0]  sum_len;

   assign sum_len = (sel_ff == SEL_K) ? sts.sl : sts.dl;

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      sel_in       = sel_ff;
      rsp_valid_in = rsp_valid_ff;
      cmd          = '0;
      cmd.sel      = sel_ff;
      cmd.idx      = cnt_ff;
      if (rsp_valid_ff && rsp_ready) rsp_valid_in = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_CHK;
            end
         end
         S_CHK: begin
            cnt_in   = '0;
            state_in = sts.raw_ok ? S_SCAN : S_SHR;
         end
         S_SCAN: begin
            cmd.scan_rd = 1'b1;
            cnt_in      = cnt_ff + CntW'(1);
            if ({1'b0, cnt_ff} == sts.kp - KpW'(1)) state_in = S_SCWT;
         end
         S_SCWT: state_in = S_SETL;
         S_SETL: state_in = S_MUL;
         S_MUL: begin
            cmd.mul  = 1'b1;
            sel_in   = SEL_RAW;
            state_in = sts.flat ? S_SHR : S_DLD;
         end
         S_DLD: begin
            cmd.div_ld = 1'b1;
            cnt_in     = '0;
            state_in   = S_DIV;
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff + CntW'(1);
            if (cnt_ff == CntW'(DivSteps - 1)) begin
               case (sel_ff)
                  SEL_RAW: state_in = S_SHR;
                  SEL_K:   state_in = S_SHK;
                  default: state_in = S_OUT;
               endcase
            end
         end
         S_SHR: begin
            cmd.shift_raw = 1'b1;
            state_in      = S_CHK2;
         end
         S_CHK2: begin
            cnt_in   = '0;
            sel_in   = SEL_K;
            state_in = sts.k_ok ? S_SUM : S_SHK;
         end
         S_SUM: begin
            cmd.sum_add = 1'b1;
            cnt_in      = cnt_ff + CntW'(1);
            if (cnt_ff == {1'b0, sum_len - SmW'(1)}) state_in = S_DLD;
         end
         S_SHK: begin
            cmd.shift_k = 1'b1;
            state_in    = S_CHK3;
         end
         S_CHK3: begin
            cnt_in   = '0;
            sel_in   = SEL_D;
            state_in = sts.d_ok ? S_SUM : S_OUT;
         end
         S_OUT: begin
            // output register must be free before the item is handed over
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.load_out = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         sel_ff       <= SEL_RAW;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         sel_ff       <= sel_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

@@ rtl/core/stochastic_rsi_filter.sv @@
// ----------------------------------------------------------------------------
// stochastic_rsi_filter
// Stochastic RSI: rolling min/max over k_period samples, raw percent,
// %K and %D moving averages.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one RSI sample per item (valid/ready). rsp_* returns one
//   result item per input item, in order (valid/ready). csr_we writes one
//   length register per cycle (index 0 k_period, 1 smooth_len, 2 d_len);
//   write only while no item is in flight.
//   Per item, accept to result valid: ring scan, scale, raw division,
//   %K sum and division, %D sum and division, output; steps made needless
//   by a window not yet valid or by a flat range are skipped, so items
//   finish sooner while windows are still filling. The single-ported
//   sample ring (one entry read per cycle) and the bit-serial divider,
//   shared by the raw ratio and both means, bound the item rate. One
//   item is in work at a time; req_ready is high only while the sequencer
//   is idle.
//   A finished result sits in the output register; the next item is
//   accepted meanwhile and, if the receiver still stalls when it is done,
//   the sequencer holds it until rsp_ready frees the register.
//   Reset clears run counts, ring pointer and handshakes and restores the
//   lengths to 14, 3, 3; no clearing pass is needed.
// ----------------------------------------------------------------------------
module stochastic_rsi_filter import srsi_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_we,
   input  logic [CsrIdxW-1:0]  csr_index,
   input  logic [KpW-1:0]      csr_wdata,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [ValW-1:0]     req_rsi_value,
   input  logic                req_rsi_valid,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [ValW-1:0]     rsp_k_value,
   output logic                rsp_k_valid,
   output logic [ValW-1:0]     rsp_d_value,
   output logic                rsp_d_valid
);

   srsi_cmd_type cmd;
   srsi_sts_type sts;

   srsi_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   srsi_dp u_dp (
      .clock         (clock),
      .reset         (reset),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .req_rsi_value (req_rsi_value),
      .req_rsi_valid (req_rsi_valid),
      .cmd           (cmd),
      .sts           (sts),
      .rsp_k_value   (rsp_k_value),
      .rsp_k_valid   (rsp_k_valid),
      .rsp_d_value   (rsp_d_value),
      .rsp_d_valid   (rsp_d_valid)
   );

endmodule

@@ rtl/core/srsi_checker.sv @@
// ----------------------------------------------------------------------------
// srsi_checker
// Port-level checks for the stochastic RSI filter, bound to the top level.
// ----------------------------------------------------------------------------
module srsi_checker import srsi_pkg::*; (
   input logic            clock,
   input logic            reset,
   input logic            req_valid,
   input logic            req_ready,
   input logic            rsp_valid,
   input logic            rsp_ready,
   input logic [ValW-1:0] rsp_k_value,
   input logic            rsp_k_valid,
   input logic [ValW-1:0] rsp_d_value,
   input logic            rsp_d_valid
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_k_value)
                                  && $stable(rsp_d_value))
      else $error("result changed while stalled");

   // one item in work at a time
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("item accepted while busy");

   a_d_needs_k: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_d_valid |-> rsp_k_valid)
      else $error("percent D valid without percent K");

   a_undef_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_k_valid || rsp_k_value == '0)
                    && (rsp_d_valid || rsp_d_value == '0))
      else $error("undefined result not zero");

endmodule

bind stochastic_rsi_filter srsi_checker u_srsi_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_ready   (req_ready),
   .rsp_valid   (rsp_valid),
   .rsp_ready   (rsp_ready),
   .rsp_k_value (rsp_k_value),
   .rsp_k_valid (rsp_k_valid),
   .rsp_d_value (rsp_d_value),
   .rsp_d_valid (rsp_d_valid)
);

@@ bench/stochastic_rsi_filter_tb.sv @@
// ----------------------------------------------------------------------------
// stochastic_rsi_filter_tb
// Drives RSI samples through the stochastic RSI filter and checks the
// %K and %D values of every result against a cycle-free predictor.
// ----------------------------------------------------------------------------
module stochastic_rsi_filter_tb import srsi_pkg::*; ();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int LenMaxK   = 64;
   localparam int LenMaxS   = 16;
   localparam int LenMaxD   = 16;
   localparam int ValTop    = 100 << 16;
   localparam int CycleCap  = 4000000;

   typedef struct packed {
      logic [ValW-1:0] k_value;
      logic            k_valid;
      logic [ValW-1:0] d_value;
      logic            d_valid;
   } srsi_result_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                csr_we = 1'b0;
   logic [CsrIdxW-1:0]  csr_index = '0;
   logic [KpW-1:0]      csr_wdata = '0;
   logic                req_valid = 1'b0;
   logic                req_ready;
   logic [ValW-1:0]     req_rsi_value = '0;
   logic                req_rsi_valid = 1'b0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   logic [ValW-1:0]     rsp_k_value;
   logic                rsp_k_valid;
   logic [ValW-1:0]     rsp_d_value;
   logic                rsp_d_valid;

   stochastic_rsi_filter DUT (.*);

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // predictor state
   logic [6:0]      reg_kp;
   logic [4:0]      reg_sl;
   logic [4:0]      reg_dl;
   logic [ValW-1:0] ring [LenMaxK];
   int unsigned     ring_run, ring_ptr;
   logic [ValW-1:0] raw_hist [LenMaxS];
   int unsigned     raw_run;
   logic [ValW-1:0] k_hist [LenMaxD];
   int unsigned     k_run;

   srsi_result_type expected_q[$];
   int  send_idle_pct = 0;
   int  recv_stall_pct = 0;
   int  mismatches = 0;
   int  items_sent = 0;
   int  results_seen = 0;
   longint cycles = 0;

   function automatic int unsigned eff_len(int unsigned v, int unsigned mx);
      if (v == 0) return 1;
      if (v > mx) return mx;
      return v;
   endfunction

   function automatic srsi_result_type predict_stoch(logic [ValW-1:0] v, logic ok);
      srsi_result_type r;
      int unsigned kp, sl, dl, slot;
      logic [ValW-1:0] mn, mx, e, raw, kv, dv;
      longint unsigned s;
      logic raw_ok, k_ok, d_ok;
      kp = eff_len(reg_kp, LenMaxK);
      sl = eff_len(reg_sl, LenMaxS);
      dl = eff_len(reg_dl, LenMaxD);
      slot = ring_ptr;
      ring[slot] = v;
      ring_run = !ok ? 0 : (ring_run < LenMaxK ? ring_run + 1 : LenMaxK);
      ring_ptr = (slot + 1) % LenMaxK;
      raw_ok = ring_run >= kp;
      raw = '0;
      if (raw_ok) begin
         mn = '1;
         mx = '0;
         for (int j = 0; j < kp; j++) begin
            e = ring[(slot + LenMaxK - j) % LenMaxK];
            if (e < mn) mn = e;
            if (e > mx) mx = e;
         end
         if (mx != mn)
            raw = ValW'((longint'(v - mn) * longint'(ValTop)) / longint'(mx - mn));
      end
      raw_run = !raw_ok ? 0 : (raw_run < LenMaxS ? raw_run + 1 : LenMaxS);
      k_ok = raw_run >= sl;
      for (int i = LenMaxS - 1; i > 0; i--) raw_hist[i] = raw_hist[i-1];
      raw_hist[0] = raw;
      s = 0;
      for (int i = 0; i < sl; i++) s += raw_hist[i];
      kv = k_ok ? ValW'(s / sl) : '0;
      k_run = !k_ok ? 0 : (k_run < LenMaxD ? k_run + 1 : LenMaxD);
      d_ok = k_run >= dl;
      for (int i = LenMaxD - 1; i > 0; i--) k_hist[i] = k_hist[i-1];
      k_hist[0] = kv;
      s = 0;
      for (int i = 0; i < dl; i++) s += k_hist[i];
      dv = d_ok ? ValW'(s / dl) : '0;
      r.k_value = kv;
      r.k_valid = k_ok;
      r.d_value = dv;
      r.d_valid = d_ok;
      return r;
   endfunction

   // valid stays up between back-to-back items; it drops only when idling
   // or draining
   task automatic send_sample(logic [ValW-1:0] v, logic ok);
      while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_rsi_value <= v;
      req_rsi_valid <= ok;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      expected_q.push_back(predict_stoch(v, ok));
      items_sent++;
   endtask

   // block idle: all results back plus a margin for the sequencer to settle
   task automatic drain_results();
      req_valid <= 1'b0;
      while (expected_q.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   task automatic write_csr(logic [CsrIdxW-1:0] idx, logic [KpW-1:0] val);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      if (idx == CSR_K_PERIOD) reg_kp = val;
      else if (idx == CSR_SMOOTH) reg_sl = val[4:0];
      else if (idx == CSR_D_LEN) reg_dl = val[4:0];
   endtask

   task automatic set_lengths(int kp, int sl, int dl);
      drain_results();
      write_csr(CSR_K_PERIOD, KpW'(kp));
      write_csr(CSR_SMOOTH, KpW'(sl));
      write_csr(CSR_D_LEN, KpW'(dl));
      csr_we <= 1'b0;
   endtask

   function automatic logic [ValW-1:0] rand_rsi();
      int unsigned sel;
      sel = $urandom_range(9);
      if (sel == 0) return ValW'(ValTop);
      if (sel == 1) return '0;
      if (sel == 2) return ValW'($urandom);          // above 100 too
      if (sel == 3) return ValW'(50 << 16);          // flat runs
      return ValW'($urandom_range(ValTop));
   endfunction

   task automatic test_directed();
      // extremes, flat window, invalid sample, above-100 sample
      set_lengths(3, 1, 1);
      send_sample('0, 1'b1);
      send_sample(ValW'(ValTop), 1'b1);
      send_sample(ValW'(ValTop / 2), 1'b1);
      send_sample('1, 1'b1);
      send_sample(ValW'(1), 1'b1);
      send_sample(ValW'(1), 1'b1);
      send_sample(ValW'(1), 1'b1);
      send_sample(ValW'(ValTop), 1'b0);
      send_sample(ValW'(12345), 1'b1);
      send_sample(ValW'(ValTop), 1'b1);
      send_sample(ValW'(0), 1'b1);
      set_lengths(0, 0, 0);
      send_sample(ValW'(777), 1'b1);
      send_sample(ValW'(ValTop), 1'b1);
      set_lengths(127, 31, 31);
      for (int i = 0; i < 10; i++) send_sample(rand_rsi(), 1'b1);
   endtask

   task automatic test_random(int n, int kp, int sl, int dl, int sidle, int rstall);
      set_lengths(kp, sl, dl);
      send_idle_pct = sidle;
      recv_stall_pct = rstall;
      for (int i = 0; i < n; i++)
         send_sample(rand_rsi(), $urandom_range(199) != 0);
   endtask

   task automatic test_config_midstream();
      send_idle_pct = 0;
      recv_stall_pct = 0;
      set_lengths(5, 4, 2);
      for (int i = 0; i < 30; i++) send_sample(rand_rsi(), 1'b1);
      // history kept across a change of lengths
      set_lengths(8, 2, 5);
      for (int i = 0; i < 30; i++) send_sample(rand_rsi(), 1'b1);
      set_lengths(64, 16, 16);
      for (int i = 0; i < 110; i++) send_sample(rand_rsi(), 1'b1);
   endtask

   // result checker
   always @(posedge clock) begin
      srsi_result_type got, want;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            got = '{rsp_k_value, rsp_k_valid, rsp_d_value, rsp_d_valid};
            results_seen++;
            if (expected_q.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("Unexpected result item %p", got);
            end else begin
               want = expected_q.pop_front();
               if (got !== want) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("Mismatch: expected k=%0d/%0b d=%0d/%0b got k=%0d/%0b d=%0d/%0b",
                              want.k_value, want.k_valid, want.d_value, want.d_valid,
                              got.k_value, got.k_valid, got.d_value, got.d_valid);
               end
            end
         end
         rsp_ready <= (recv_stall_pct == 0) || ($urandom_range(99) >= recv_stall_pct);
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CycleCap) begin
         $display("Timeout after %0d cycles", cycles);
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   initial begin
      reg_kp = 7'd14;
      reg_sl = 5'd3;
      reg_dl = 5'd3;
      ring_run = 0;
      ring_ptr = 0;
      raw_run = 0;
      k_run = 0;
      foreach (raw_hist[i]) raw_hist[i] = '0;
      foreach (k_hist[i]) k_hist[i] = '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_config_midstream();
      test_random(210, 14, 3, 3, 0, 0);
      test_random(200, 5, 2, 4, 47, 0);
      test_random(200, 2, 16, 16, 0, 47);
      test_random(150, 1, 1, 1, 6, 6);
      test_random(100, 20, 8, 3, 47, 47);
      drain_results();
      repeat (200) @(posedge clock);
      $display("Sent %0d items and checked %0d results over lengths 0 to 127",
               items_sent, results_seen);
      $display("with invalid samples, flat windows and random idle/stall phases.");
      if (mismatches == 0 && expected_q.size() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("%0d mismatches, %0d results missing", mismatches, expected_q.size());
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
